FILE: rtl/svv_pkg.sv
// ----------------------------------------------------------------------------
// svv_pkg
// Shared types and constants of the semantic version string validator.
// ----------------------------------------------------------------------------
`default_nettype none

package svv_pkg;

  // Width of one character code unit
  localparam int unsigned CharBits = 16;

  // APB register map
  localparam int unsigned AddrBits = 3;
  localparam int unsigned DataBits = 32;
  localparam logic [AddrBits-3:0] RegTagMode = '0;

  // Character codes
  localparam logic [CharBits-1:0] ChV     = CharBits'(8'h76);
  localparam logic [CharBits-1:0] ChMinus = CharBits'(8'h2D);
  localparam logic [CharBits-1:0] ChPlus  = CharBits'(8'h2B);
  localparam logic [CharBits-1:0] ChDot   = CharBits'(8'h2E);
  localparam logic [CharBits-1:0] ChZero  = CharBits'(8'h30);
  localparam logic [CharBits-1:0] ChNine  = CharBits'(8'h39);
  localparam logic [CharBits-1:0] ChTab   = CharBits'(8'h09);
  localparam logic [CharBits-1:0] ChCr    = CharBits'(8'h0D);
  localparam logic [CharBits-1:0] ChSpace = CharBits'(8'h20);
  localparam logic [CharBits-1:0] ChLowA  = CharBits'(8'h61);
  localparam logic [CharBits-1:0] ChLowZ  = CharBits'(8'h7A);
  localparam logic [CharBits-1:0] ChUpA   = CharBits'(8'h41);
  localparam logic [CharBits-1:0] ChUpZ   = CharBits'(8'h5A);

  // Token length saturates here, base part count saturates at BaseSat
  localparam logic [1:0] TokSat      = 2'd2;
  localparam logic [2:0] BaseSat     = 3'd4;
  localparam logic [2:0] BaseNeeded  = 3'd3;

  // Parse section, one-hot
  typedef enum logic [4:0] {
    SecStart = 5'b00001,
    SecLead  = 5'b00010,
    SecBase  = 5'b00100,
    SecPre   = 5'b01000,
    SecMeta  = 5'b10000
  } section_e;

  // Per-string parse state
  typedef struct packed {
    section_e   section;
    logic       error_seen;
    logic       trailing_space;
    logic       prev_was_dot;
    logic [1:0] token_length;
    logic       token_lead_zero;
    logic       token_all_digits;
    logic [2:0] base_part_count;
    logic       prerelease_nonempty;
  } state_t;

  localparam state_t StateReset = '{
    section:             SecStart,
    error_seen:          1'b0,
    trailing_space:      1'b0,
    prev_was_dot:        1'b0,
    token_length:        2'd0,
    token_lead_zero:     1'b0,
    token_all_digits:    1'b1,
    base_part_count:     3'd0,
    prerelease_nonempty: 1'b0
  };

  // Result beat payload
  typedef struct packed {
    logic in_base;
    logic valid_res;
    logic has_prerelease;
    logic done_res;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/svv_if.sv
// ----------------------------------------------------------------------------
// svv_if
// Valid/ready channels: character input beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface svv_in_if
  import svv_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CharBits-1:0] ch;
  logic                last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface svv_out_if;
  logic valid;
  logic ready;
  logic in_base;
  logic valid_res;
  logic has_prerelease;
  logic done_res;

  modport source (output valid, output in_base, output valid_res,
                  output has_prerelease, output done_res, input ready);
  modport sink   (input valid, input in_base, input valid_res,
                  input has_prerelease, input done_res, output ready);
endinterface

`default_nettype wire

FILE: rtl/svv_apb_regs.sv
// ----------------------------------------------------------------------------
// svv_apb_regs
// APB configuration register file: holds the tag mode bit.
// ----------------------------------------------------------------------------
`default_nettype none

module svv_apb_regs
  import svv_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrBits-1:0] paddr,
  input  wire logic [DataBits-1:0] pwdata,
  output logic      [DataBits-1:0] prdata,
  output logic                     pready,
  output logic                     tag_mode_o
);

  logic tag_mode_q;
  logic tag_hit;

  assign pready  = 1'b1;
  assign tag_hit = (paddr[AddrBits-1:2] == RegTagMode);

  // Register write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && tag_hit) begin
      tag_mode_q <= pwdata[0];
    end
  end

  // Read back
  assign prdata     = tag_hit ? {{(DataBits-1){1'b0}}, tag_mode_q} : '0;
  assign tag_mode_o = tag_mode_q;

endmodule

`default_nettype wire

FILE: rtl/svv_step.sv
// ----------------------------------------------------------------------------
// svv_step
// Per-character parse step: next parse state and the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module svv_step
  import svv_pkg::*;
(
  input  wire logic [CharBits-1:0] ch_i,
  input  wire logic                last_i,
  input  wire logic                tag_mode_i,
  input  wire state_t              state_i,
  output state_t                   state_o,
  output result_t                  result_o
);

  function automatic logic is_digit(input logic [CharBits-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_space(input logic [CharBits-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_ident(input logic [CharBits-1:0] c);
    return is_digit(c) || ((c >= ChLowA) && (c <= ChLowZ)) ||
           ((c >= ChUpA) && (c <= ChUpZ)) || (c == ChMinus);
  endfunction

  function automatic state_t token_clear(input state_t s);
    state_t r;
    r = s;
    r.token_length     = 2'd0;
    r.token_lead_zero  = 1'b0;
    r.token_all_digits = 1'b1;
    return r;
  endfunction

  function automatic state_t token_add(input state_t s, input logic [CharBits-1:0] c);
    state_t r;
    r = s;
    if (s.token_length == 2'd0) r.token_lead_zero = (c == ChZero);
    if (!is_digit(c)) r.token_all_digits = 1'b0;
    if (s.token_length < TokSat) r.token_length = s.token_length + 2'd1;
    return r;
  endfunction

  // Finish a base part: leading zero check and part count
  function automatic state_t close_base(input state_t s);
    state_t r;
    r = s;
    if (s.token_length != 2'd0) begin
      if ((s.token_length >= TokSat) && s.token_lead_zero) r.error_seen = 1'b1;
      if (s.base_part_count < BaseSat) r.base_part_count = s.base_part_count + 3'd1;
    end
    return token_clear(r);
  endfunction

  // Finish a prerelease identifier: numeric ones take no leading zero
  function automatic state_t close_pre(input state_t s);
    state_t r;
    r = s;
    if ((s.token_length >= TokSat) && s.token_all_digits && s.token_lead_zero) begin
      r.error_seen = 1'b1;
    end
    return token_clear(r);
  endfunction

  always_comb begin
    state_t n;
    logic   handled;
    logic   is_dot;
    logic   base_flag;
    logic   ok;

    n         = state_i;
    handled   = 1'b0;
    base_flag = 1'b0;
    ok        = 1'b0;
    is_dot    = (ch_i == ChDot);

    // First raw character: tag check in tag mode
    if (n.section == SecStart) begin
      n.section = SecLead;
      if (tag_mode_i) begin
        if (ch_i != ChV) n.error_seen = 1'b1;
        handled = 1'b1;
      end
    end

    if (!handled) begin
      if (is_space(ch_i)) begin
        if (n.section != SecLead) n.trailing_space = 1'b1;
      end else begin
        if (n.trailing_space) n.error_seen = 1'b1;
        if (is_dot && ((n.section == SecLead) || n.prev_was_dot)) n.error_seen = 1'b1;
        if (n.section == SecLead) n.section = SecBase;
        n.prev_was_dot = is_dot;
        case (n.section)
          SecBase: begin
            if ((ch_i == ChMinus) || (ch_i == ChPlus)) begin
              n = close_base(n);
              if (n.base_part_count != BaseNeeded) n.error_seen = 1'b1;
              n.section = (ch_i == ChMinus) ? SecPre : SecMeta;
            end else begin
              base_flag = 1'b1;
              if (is_dot) begin
                n = close_base(n);
              end else begin
                if (!is_digit(ch_i)) n.error_seen = 1'b1;
                n = token_add(n, ch_i);
              end
            end
          end
          SecPre: begin
            if (ch_i == ChPlus) begin
              n = close_pre(n);
              if (!n.prerelease_nonempty) n.error_seen = 1'b1;
              n.section = SecMeta;
            end else begin
              n.prerelease_nonempty = 1'b1;
              if (is_dot) begin
                n = close_pre(n);
              end else begin
                if (!is_ident(ch_i)) n.error_seen = 1'b1;
                n = token_add(n, ch_i);
              end
            end
          end
          default: begin
            // metadata: token length counts the whole section
            if (!is_ident(ch_i) && !is_dot) n.error_seen = 1'b1;
            if (n.token_length < TokSat) n.token_length = n.token_length + 2'd1;
          end
        endcase
      end
    end

    // Verdict on the final character
    if (last_i) begin
      case (n.section)
        SecBase: begin
          n = close_base(n);
          if (n.base_part_count != BaseNeeded) n.error_seen = 1'b1;
        end
        SecPre: begin
          n = close_pre(n);
          if (!n.prerelease_nonempty) n.error_seen = 1'b1;
        end
        SecMeta: begin
          if (n.token_length == 2'd0) n.error_seen = 1'b1;
        end
        default: begin
          n.error_seen = 1'b1;
        end
      endcase
      if (n.prev_was_dot) n.error_seen = 1'b1;
      ok = !n.error_seen;
      result_o.has_prerelease = ok && n.prerelease_nonempty;
      n = StateReset;
    end else begin
      result_o.has_prerelease = 1'b0;
    end

    result_o.in_base   = base_flag;
    result_o.valid_res = ok;
    result_o.done_res  = last_i;
    state_o            = n;
  end

endmodule

`default_nettype wire

FILE: rtl/semver_string_validator.sv
// ----------------------------------------------------------------------------
// semver_string_validator
// Streaming semantic version string checker, one character per beat.
// ----------------------------------------------------------------------------
// Takes one UTF-16 code unit per input beat and returns one result beat per
// character, at a sustained rate of one character per clock while out_o.ready
// stays high. The character lands in an input register, then one parse step
// updates the string state and fills the result register. The input side
// keeps accepting while a result waits, as long as the input register can
// move on. in_base flags characters of major.minor.patch; the beat with
// done_res set carries valid_res and has_prerelease, and the parse state
// returns to its reset value for the next string. The user must write tag_mode
// (APB offset 0) only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module semver_string_validator
  import svv_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  svv_in_if.sink                   in_i,
  svv_out_if.source                out_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrBits-1:0] paddr,
  input  wire logic [DataBits-1:0] pwdata,
  output logic      [DataBits-1:0] prdata,
  output logic                     pready
);

  logic                s1_valid_q;
  logic [CharBits-1:0] s1_ch_q;
  logic                s1_last_q;
  logic                s2_load;
  logic                out_valid_q;
  result_t             res_q, res_d;
  state_t              state_q, state_d;
  logic                tag_mode;

  // Configuration registers
  svv_apb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .tag_mode_o (tag_mode)
  );

  // Pipeline handshake
  assign s2_load    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s2_load;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_ch_q   <= in_i.ch;
      s1_last_q <= in_i.last;
    end
  end

  // Parse step
  svv_step u_step (
    .ch_i       (s1_ch_q),
    .last_i     (s1_last_q),
    .tag_mode_i (tag_mode),
    .state_i    (state_q),
    .state_o    (state_d),
    .result_o   (res_d)
  );

  // String state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (s2_load) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.in_base        = res_q.in_base;
  assign out_o.valid_res      = res_q.valid_res;
  assign out_o.has_prerelease = res_q.has_prerelease;
  assign out_o.done_res       = res_q.done_res;

  // Checks
  a_ready_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with result register empty");

  a_state_clears_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_load && s1_last_q) |=> (state_q == StateReset))
    else $error("parse state not cleared after final character");

  a_verdict_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.valid_res || res_q.has_prerelease)) |-> res_q.done_res)
    else $error("verdict flag on a non-final beat");

  a_pre_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.has_prerelease) |-> res_q.valid_res)
    else $error("prerelease flagged on an invalid string");

  a_out_filled_by_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s2_load))
    else $error("result appeared without a parse step");

endmodule

`default_nettype wire
